FILE: rtl/set_assoc_writeback_cache_defines.svh
// assertion macros for the cache block
`ifndef SET_ASSOC_WRITEBACK_CACHE_DEFINES_SVH
`define SET_ASSOC_WRITEBACK_CACHE_DEFINES_SVH
// property that holds outside reset
`define SAWC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication checked next cycle
`define SAWC_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);
`endif

FILE: rtl/sawc_pkg.sv
// shared types, constants and state codes of the cache
package sawc_pkg;
	localparam int SETS_DEF       = 16;
	localparam int WAYS_DEF       = 4;
	localparam int LINE_BYTES_DEF = 16;
	localparam int ADDR_BITS_DEF  = 16;
	localparam int MEM_BITS       = 16;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [15:0] address;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] read_data;
		logic       evicted;
		logic [3:0] evicted_set;
		logic [7:0] evicted_tag;
		logic       evicted_dirty;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_WB_RD,
		ST_WB_WR,
		ST_FILL_RD,
		ST_FILL_WR,
		ST_ACCESS,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_step;
		logic capture;
		logic lookup;
		logic wb_read;
		logic wb_write;
		logic fill_read;
		logic fill_write;
		logic access;
		logic finish;
		logic cnt_clr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic hit;
		logic evict_dirty;
		logic cnt_last;
	} sts_t;
endpackage

FILE: rtl/set_assoc_writeback_cache.sv
// top level of the set associative write-back cache
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | sawc_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_ready | sawc_pkg::rsp_t
// a hit passes the lookup, access and done states before its result is registered
// a miss adds a read and a write state per line byte for the fill
// and a read and write state per byte for a dirty victim (single-port line and memory rams)
// after reset a clearing pass zeroes all 65536 memory bytes; no item is taken then
// the result register holds while rsp_ready is low; items are taken in idle once it is free
`include "set_assoc_writeback_cache_defines.svh"
module set_assoc_writeback_cache #(
	parameter int SETS       = sawc_pkg::SETS_DEF,
	parameter int WAYS       = sawc_pkg::WAYS_DEF,
	parameter int LINE_BYTES = sawc_pkg::LINE_BYTES_DEF,
	parameter int ADDR_BITS  = sawc_pkg::ADDR_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  sawc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output sawc_pkg::rsp_t rsp
);
	sawc_pkg::cmd_t cmd;
	sawc_pkg::sts_t sts;

	sawc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req_valid), .in_ready(req_ready),
		.out_valid(rsp_valid), .out_ready(rsp_ready), .sts(sts), .cmd(cmd)
	);

	sawc_datapath #(
		.SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES), .ADDR_BITS(ADDR_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req),
		.cmd(cmd), .sts(sts), .rsp(rsp)
	);

	`SAWC_ASSERT(a_evict_fields,
		!rsp_valid || rsp.evicted || (!rsp.evicted_dirty && rsp.evicted_tag == 8'd0),
		"eviction fields set without eviction")
	`SAWC_ASSERT(a_hit_no_evict, !rsp_valid || !(rsp.hit && rsp.evicted),
		"hit reported with eviction")
	`SAWC_ASSERT_NEXT(a_one_cmd, 1'b1,
		$onehot0({cmd.wb_write, cmd.fill_write, cmd.access, cmd.clear_step}),
		"overlapping memory commands")
endmodule

FILE: rtl/sawc_ram.sv
// generic single port ram with registered read
module sawc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: rtl/sawc_ctrl.sv
// controller state machine of the cache
module sawc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sawc_pkg::sts_t      sts,
	output sawc_pkg::cmd_t      cmd
);
	sawc_pkg::state_t state_q, state_d;
	logic busy_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sawc_pkg::ST_CLEAR;
			busy_out_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sawc_pkg::ST_DONE) begin
				busy_out_q <= 1'b1;
			end else if (out_ready) begin
				busy_out_q <= 1'b0;
			end
		end
	end

	assign out_valid = busy_out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sawc_pkg::ST_CLEAR: begin
				if (sts.clear_last) state_d = sawc_pkg::ST_IDLE;
			end
			sawc_pkg::ST_IDLE: begin
				if (in_valid && (!busy_out_q || out_ready)) state_d = sawc_pkg::ST_LOOKUP;
			end
			sawc_pkg::ST_LOOKUP: begin
				if (sts.hit) state_d = sawc_pkg::ST_ACCESS;
				else if (sts.evict_dirty) state_d = sawc_pkg::ST_WB_RD;
				else state_d = sawc_pkg::ST_FILL_RD;
			end
			sawc_pkg::ST_WB_RD: state_d = sawc_pkg::ST_WB_WR;
			sawc_pkg::ST_WB_WR: begin
				state_d = sts.cnt_last ? sawc_pkg::ST_FILL_RD : sawc_pkg::ST_WB_RD;
			end
			sawc_pkg::ST_FILL_RD: state_d = sawc_pkg::ST_FILL_WR;
			sawc_pkg::ST_FILL_WR: begin
				state_d = sts.cnt_last ? sawc_pkg::ST_ACCESS : sawc_pkg::ST_FILL_RD;
			end
			sawc_pkg::ST_ACCESS: state_d = sawc_pkg::ST_DONE;
			sawc_pkg::ST_DONE: state_d = sawc_pkg::ST_IDLE;
			default: state_d = sawc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			sawc_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
			sawc_pkg::ST_IDLE: begin
				// result register must be free before taking a new item
				in_ready    = !busy_out_q || out_ready;
				cmd.capture = in_valid && in_ready;
			end
			sawc_pkg::ST_LOOKUP: begin
				cmd.lookup  = 1'b1;
				cmd.cnt_clr = 1'b1;
			end
			sawc_pkg::ST_WB_RD: cmd.wb_read = 1'b1;
			sawc_pkg::ST_WB_WR: begin
				cmd.wb_write = 1'b1;
				cmd.cnt_clr  = sts.cnt_last;
			end
			sawc_pkg::ST_FILL_RD: cmd.fill_read = 1'b1;
			sawc_pkg::ST_FILL_WR: cmd.fill_write = 1'b1;
			sawc_pkg::ST_ACCESS: cmd.access = 1'b1;
			sawc_pkg::ST_DONE: cmd.finish = 1'b1;
			default: ;
		endcase
	end
endmodule

FILE: rtl/sawc_datapath.sv
// tag store, line data, backing memory and result register
module sawc_datapath #(
	parameter int SETS       = sawc_pkg::SETS_DEF,
	parameter int WAYS       = sawc_pkg::WAYS_DEF,
	parameter int LINE_BYTES = sawc_pkg::LINE_BYTES_DEF,
	parameter int ADDR_BITS  = sawc_pkg::ADDR_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sawc_pkg::req_t  req,
	input  sawc_pkg::cmd_t  cmd,
	output sawc_pkg::sts_t  sts,
	output sawc_pkg::rsp_t  rsp
);
	localparam int OFF_BITS = $clog2(LINE_BYTES + 1) - 1;
	localparam int IDX_BITS = $clog2(SETS + 1) - 1;
	localparam int LOW_BITS = OFF_BITS + IDX_BITS;
	localparam int TAG_W    = (LOW_BITS < ADDR_BITS) ? ADDR_BITS - LOW_BITS : 1;
	localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int CNT_W    = $clog2(LINE_BYTES + 1);
	localparam int LINES    = SETS * WAYS;
	localparam int LINE_W   = $clog2(LINES) > 0 ? $clog2(LINES) : 1;
	localparam int BYTE_A_W = $clog2(LINES * LINE_BYTES) > 0 ? $clog2(LINES * LINE_BYTES) : 1;
	localparam int MEM_D    = 1 << sawc_pkg::MEM_BITS;
	localparam int OFF_W    = (OFF_BITS > 0) ? OFF_BITS : 1;

	typedef logic [sawc_pkg::MEM_BITS-1:0] maddr_t;

	// per-set line state in flip-flops, all ways of a set in one entry
	logic [WAYS-1:0]                valid_q [SETS];
	logic [WAYS-1:0]                dirty_q [SETS];
	logic [WAYS-1:0][TAG_W-1:0]     tag_q   [SETS];
	logic [WAYS-1:0][WAY_BITS-1:0]  rank_q  [SETS];

	logic [ADDR_BITS-1:0] addr_q;
	logic                 kind_q;
	logic [7:0]           wdata_q;
	logic [SET_W-1:0]     set_q;
	logic [TAG_W-1:0]     tagv_q;
	logic [OFF_W-1:0]     off_q;
	logic [WAY_BITS-1:0]  way_q;
	logic                 hit_q;
	logic                 ev_q, evd_q;
	logic [TAG_W-1:0]     evtag_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [sawc_pkg::MEM_BITS:0] clr_q;
	sawc_pkg::rsp_t       rsp_q;

	// address split
	logic [ADDR_BITS-1:0] a_in;
	logic [SET_W-1:0]     set_in;
	logic [TAG_W-1:0]     tag_in;
	logic [OFF_W-1:0]     off_in;
	always_comb begin
		a_in   = req.address[ADDR_BITS-1:0];
		off_in = '0;
		set_in = '0;
		tag_in = '0;
		if (OFF_BITS > 0) off_in = OFF_W'(a_in & ((ADDR_BITS'(1) << OFF_BITS) - 1'b1));
		if (IDX_BITS > 0) set_in = SET_W'((a_in >> OFF_BITS) & ((ADDR_BITS'(1) << IDX_BITS) - 1'b1));
		if (LOW_BITS < ADDR_BITS) tag_in = TAG_W'(a_in >> LOW_BITS);
	end

	// lookup over the ways of the set
	logic                hit_c, inv_c;
	logic [WAY_BITS-1:0] hway_c, iway_c, lway_c, way_c;
	always_comb begin
		hit_c  = 1'b0;
		inv_c  = 1'b0;
		hway_c = '0;
		iway_c = '0;
		lway_c = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid_q[set_q][WAY_BITS'(w)] && tag_q[set_q][WAY_BITS'(w)] == tagv_q) begin
				hit_c  = 1'b1;
				hway_c = WAY_BITS'(w);
			end
			if (!valid_q[set_q][WAY_BITS'(w)]) begin
				inv_c  = 1'b1;
				iway_c = WAY_BITS'(w);
			end
			if (rank_q[set_q][WAY_BITS'(w)] == '0) begin
				lway_c = WAY_BITS'(w);
			end
		end
		way_c = hit_c ? hway_c : (inv_c ? iway_c : lway_c);
	end

	logic [LINE_W-1:0] line_c;
	assign line_c = LINE_W'(set_q) * LINE_W'(WAYS) + LINE_W'(way_q);

	// memories
	logic                we_l, we_m;
	logic [BYTE_A_W-1:0] a_l;
	logic [7:0]          wd_l, rd_l, wd_m, rd_m;
	maddr_t              a_m, wb_base, fill_base;

	assign wb_base   = maddr_t'((32'(evtag_q) << LOW_BITS) + (32'(set_q) << OFF_BITS));
	assign fill_base = maddr_t'(32'(addr_q) & ~((32'd1 << OFF_BITS) - 32'd1));

	always_comb begin
		we_l = 1'b0;
		we_m = 1'b0;
		a_l  = BYTE_A_W'(32'(line_c) * LINE_BYTES + 32'(cnt_q));
		a_m  = fill_base + maddr_t'(cnt_q);
		wd_l = rd_m;
		wd_m = rd_l;
		if (cmd.clear_step) begin
			we_m = 1'b1;
			a_m  = clr_q[sawc_pkg::MEM_BITS-1:0];
			wd_m = '0;
		end else if (cmd.wb_read || cmd.wb_write) begin
			a_m  = wb_base + maddr_t'(cnt_q);
			we_m = cmd.wb_write;
		end else if (cmd.fill_read || cmd.fill_write) begin
			we_l = cmd.fill_write;
		end else if (cmd.access) begin
			a_l  = BYTE_A_W'(32'(line_c) * LINE_BYTES + 32'(off_q));
			we_l = (kind_q == sawc_pkg::KIND_WRITE);
			wd_l = wdata_q;
		end
	end

	// during write-back each line byte is read in the cycle before its memory write
	sawc_ram #(.WIDTH(8), .DEPTH(LINES * LINE_BYTES)) u_lines (
		.clk(clk), .we(we_l), .addr(a_l), .wdata(wd_l), .rdata(rd_l)
	);
	sawc_ram #(.WIDTH(8), .DEPTH(MEM_D)) u_mem (
		.clk(clk), .we(we_m), .addr(a_m), .wdata(wd_m), .rdata(rd_m)
	);

	assign sts.clear_last  = (clr_q == (sawc_pkg::MEM_BITS+1)'(MEM_D - 1));
	assign sts.hit         = hit_c;
	assign sts.evict_dirty = !hit_c && !inv_c && dirty_q[set_q][way_c];
	assign sts.cnt_last    = (cnt_q == CNT_W'(LINE_BYTES - 1));
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			cnt_q <= '0;
			for (int s = 0; s < SETS; s++) begin
				valid_q[s] <= '0;
				dirty_q[s] <= '0;
				for (int w = 0; w < WAYS; w++) begin
					tag_q[s][w]  <= '0;
					rank_q[s][w] <= WAY_BITS'(w);
				end
			end
		end else begin
			if (cmd.clear_step) clr_q <= clr_q + 1'b1;
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.wb_write || cmd.fill_write) cnt_q <= cnt_q + 1'b1;
			if (cmd.lookup && !hit_c) begin
				valid_q[set_q][way_c] <= 1'b1;
				dirty_q[set_q][way_c] <= 1'b0;
				tag_q[set_q][way_c]   <= tagv_q;
			end
			if (cmd.access) begin
				if (kind_q == sawc_pkg::KIND_WRITE) dirty_q[set_q][way_q] <= 1'b1;
				for (int w = 0; w < WAYS; w++) begin
					if (rank_q[set_q][WAY_BITS'(w)] > rank_q[set_q][way_q])
						rank_q[set_q][WAY_BITS'(w)] <= rank_q[set_q][WAY_BITS'(w)] - 1'b1;
				end
				rank_q[set_q][way_q] <= WAY_BITS'(WAYS - 1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q  <= a_in;
			kind_q  <= req.kind;
			wdata_q <= req.write_data;
			set_q   <= set_in;
			tagv_q  <= tag_in;
			off_q   <= off_in;
		end
		if (cmd.lookup) begin
			way_q   <= way_c;
			hit_q   <= hit_c;
			ev_q    <= !hit_c && !inv_c;
			evd_q   <= !hit_c && !inv_c && dirty_q[set_q][way_c];
			evtag_q <= tag_q[set_q][way_c];
		end
		if (cmd.finish) begin
			rsp_q.hit           <= hit_q;
			rsp_q.read_data     <= (kind_q == sawc_pkg::KIND_WRITE) ? 8'd0 : rd_l;
			rsp_q.evicted       <= ev_q;
			rsp_q.evicted_set   <= ev_q ? 4'(set_q) : 4'd0;
			rsp_q.evicted_tag   <= ev_q ? 8'(evtag_q) : 8'd0;
			rsp_q.evicted_dirty <= ev_q && evd_q;
		end
	end
endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the set associative write-back cache
`timescale 1ns / 1ps
module testbench;
	localparam int N_SETS  = 16;
	localparam int N_WAYS  = 4;
	localparam int N_BYTES = 16;
	localparam longint CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	sawc_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	sawc_pkg::rsp_t rsp;

	set_assoc_writeback_cache u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #1 clk = ~clk;

	// cache shadow state
	logic        sh_valid [N_SETS][N_WAYS];
	logic        sh_dirty [N_SETS][N_WAYS];
	logic [7:0]  sh_tag   [N_SETS][N_WAYS];
	logic [1:0]  sh_rank  [N_SETS][N_WAYS];
	logic [7:0]  sh_bytes [N_SETS][N_WAYS][N_BYTES];
	logic [7:0]  sh_mem   [65536];

	sawc_pkg::req_t  pending_reqs[$];
	sawc_pkg::rsp_t  expected_rsps[$];
	int    mismatches = 0;
	int    n_hits = 0, n_evicts = 0, n_dirty_evicts = 0, n_rsps = 0;
	bit    quiet = 1'b0;
	bit    hold_sender = 1'b0;
	int    send_gap = 0, recv_gap = 0;
	longint cycles = 0;

	function automatic sawc_pkg::rsp_t cache_access(sawc_pkg::req_t r);
		sawc_pkg::rsp_t o;
		logic [3:0] off, st;
		logic [7:0] tg;
		logic [15:0] wb;
		int w, vic;
		logic [1:0] old;
		o = '0;
		off = r.address[3:0];
		st = r.address[7:4];
		tg = r.address[15:8];
		vic = -1;
		for (w = 0; w < N_WAYS; w++)
			if (vic < 0 && sh_valid[st][w] && sh_tag[st][w] == tg) vic = w;
		o.hit = (vic >= 0);
		if (vic < 0) begin
			for (w = 0; w < N_WAYS; w++)
				if (vic < 0 && !sh_valid[st][w]) vic = w;
			if (vic < 0) begin
				for (w = 0; w < N_WAYS; w++)
					if (vic < 0 && sh_rank[st][w] == 2'd0) vic = w;
				if (vic < 0) vic = 0;
				o.evicted = 1'b1;
				o.evicted_set = st;
				o.evicted_tag = sh_tag[st][vic];
				o.evicted_dirty = sh_dirty[st][vic];
				if (sh_dirty[st][vic]) begin
					wb = {sh_tag[st][vic], st, 4'h0};
					for (w = 0; w < N_BYTES; w++) sh_mem[wb + w] = sh_bytes[st][vic][w];
				end
			end
			for (w = 0; w < N_BYTES; w++)
				sh_bytes[st][vic][w] = sh_mem[{r.address[15:4], 4'h0} + w];
			sh_tag[st][vic] = tg;
			sh_valid[st][vic] = 1'b1;
			sh_dirty[st][vic] = 1'b0;
		end
		if (r.kind == sawc_pkg::KIND_WRITE) begin
			sh_bytes[st][vic][off] = r.write_data;
			sh_dirty[st][vic] = 1'b1;
		end else begin
			o.read_data = sh_bytes[st][vic][off];
		end
		old = sh_rank[st][vic];
		for (w = 0; w < N_WAYS; w++)
			if (sh_rank[st][w] > old) sh_rank[st][w]--;
		sh_rank[st][vic] = 2'(N_WAYS - 1);
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				expected_rsps.push_back(cache_access(req));
				void'(pending_reqs.pop_front());
			end
			if (req_valid && !req_ready) begin
				// hold until transfer
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				req_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 19) == 0) begin
				send_gap <= $urandom_range(1, 15);
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 && !hold_sender) begin
				// the transferred item is already gone from the queue
				req_valid <= 1'b1;
				req <= pending_reqs[0];
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk) begin
		sawc_pkg::rsp_t e;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (rsp_valid && rsp_ready) begin
				n_rsps <= n_rsps + 1;
				if (expected_rsps.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("unexpected result %p", rsp);
				end else begin
					e = expected_rsps.pop_front();
					if (rsp.hit) n_hits <= n_hits + 1;
					if (rsp.evicted) n_evicts <= n_evicts + 1;
					if (rsp.evicted_dirty) n_dirty_evicts <= n_dirty_evicts + 1;
					if (rsp !== e) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: expected %p actual %p", e, rsp);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				recv_gap <= $urandom_range(1, 15);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_rsps.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic sawc_pkg::req_t make_req(logic k, logic [15:0] a, logic [7:0] d);
		sawc_pkg::req_t r;
		r.kind = k;
		r.address = a;
		r.write_data = d;
		return r;
	endfunction

	initial begin
		int i, s, t;
		logic [3:0] hot_set;
		for (s = 0; s < N_SETS; s++)
			for (t = 0; t < N_WAYS; t++) begin
				sh_valid[s][t] = 1'b0;
				sh_dirty[s][t] = 1'b0;
				sh_tag[s][t] = '0;
				sh_rank[s][t] = 2'(t);
				for (i = 0; i < N_BYTES; i++) sh_bytes[s][t][i] = '0;
			end
		for (i = 0; i < 65536; i++) sh_mem[i] = '0;

		// directed: extremes, read and write, eviction of clean and dirty lines
		pending_reqs.push_back(make_req(sawc_pkg::KIND_READ, 16'h0000, 8'h00));
		pending_reqs.push_back(make_req(sawc_pkg::KIND_WRITE, 16'hFFFF, 8'hFF));
		pending_reqs.push_back(make_req(sawc_pkg::KIND_READ, 16'hFFFF, 8'h00));
		pending_reqs.push_back(make_req(sawc_pkg::KIND_WRITE, 16'h0000, 8'hA5));
		pending_reqs.push_back(make_req(sawc_pkg::KIND_READ, 16'h0000, 8'hFF));
		// fill set 3 beyond its ways so dirty and clean victims leave
		for (t = 0; t < 6; t++)
			pending_reqs.push_back(make_req(t[0] ? sawc_pkg::KIND_READ : sawc_pkg::KIND_WRITE,
				{8'(t * 37), 4'h3, 4'(t)}, 8'(t * 51 + 1)));
		// bring the first lines back to read written-back data
		pending_reqs.push_back(make_req(sawc_pkg::KIND_READ, {8'd0, 4'h3, 4'h0}, 8'h00));
		pending_reqs.push_back(make_req(sawc_pkg::KIND_READ, {8'd74, 4'h3, 4'h2}, 8'h00));
		pending_reqs.push_back(make_req(sawc_pkg::KIND_WRITE, 16'h5A5A, 8'h5A));
		pending_reqs.push_back(make_req(sawc_pkg::KIND_READ, 16'hA5A5, 8'h00));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_reqs.size() == 0);
		// pause until everything has drained
		hold_sender = 1'b1;
		wait (expected_rsps.size() == 0 && !req_valid);
		hold_sender = 1'b0;

		// random: mostly a few hot sets with a handful of tags to get hits and evictions
		for (i = 0; i < 1700; i++) begin
			hot_set = 4'($urandom_range(0, 3));
			if ($urandom_range(0, 9) < 8)
				pending_reqs.push_back(make_req(1'($urandom), {8'($urandom_range(0, 6) * 41),
					hot_set, 4'($urandom)}, 8'($urandom)));
			else
				pending_reqs.push_back(make_req(1'($urandom), 16'($urandom), 8'($urandom)));
			if (i == 1500) begin
				wait (pending_reqs.size() < 50);
				quiet = 1'b1;
			end
		end
		wait (pending_reqs.size() == 0 && !req_valid);
		wait (expected_rsps.size() == 0);
		repeat (100) @(posedge clk);
		$display("covered %0d results: %0d hits, %0d evictions, %0d dirty write-backs",
			n_rsps, n_hits, n_evicts, n_dirty_evicts);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
